// ===== hdl/ffpa_pkg.sv =====
// Shared types, codes and constants of the first-fit pool allocator.
package ffpa_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW  = 17;
  localparam logic [LenW-1:0] PoolMax = LenW'(65536);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } ffpa_status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffpa_op_e;

  typedef struct packed {
    logic             op;
    logic [LenW-1:0]  size;
    logic [AddrW-1:0] address;
  } ffpa_req_t;

  typedef struct packed {
    ffpa_status_e     status;
    logic [AddrW-1:0] result_address;
  } ffpa_rsp_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
  } ffpa_ext_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} ffpa_cnt_e;
  typedef enum logic [1:0] {IX_HOLD, IX_CLR, IX_INC} ffpa_idx_e;
  typedef enum logic [1:0] {FR_I, FR_I1, FR_KM1} ffpa_frsel_e;
  typedef enum logic [1:0] {FW_I, FW_IM1, FW_K} ffpa_fwsel_e;
  typedef enum logic [2:0] {
    WD_SPLIT, WD_COPY, WD_BOTH, WD_PREV, WD_NEXT, WD_NEW
  } ffpa_fwd_e;
  typedef enum logic {LR_J, LR_J1} ffpa_lrsel_e;
  typedef enum logic {LW_LC, LW_J} ffpa_lwsel_e;
  typedef enum logic {LD_NEW, LD_COPY} ffpa_lwd_e;

  typedef struct packed {
    logic         req_load;
    ffpa_idx_e    i_op;
    ffpa_idx_e    j_op;
    logic         k_load;
    logic         k_dec;
    logic         f_rd_en;
    ffpa_frsel_e  f_rd_sel;
    logic         f_we;
    ffpa_fwsel_e  f_wa_sel;
    ffpa_fwd_e    f_wd_sel;
    logic         l_rd_en;
    ffpa_lrsel_e  l_rd_sel;
    logic         l_we;
    ffpa_lwsel_e  l_wa_sel;
    ffpa_lwd_e    l_wd_sel;
    logic         prev_save;
    logic         len_save;
    logic         grant_save;
    ffpa_cnt_e    fc_op;
    ffpa_cnt_e    lc_op;
    logic         done;
    ffpa_status_e status;
  } ffpa_cmd_t;

  typedef struct packed {
    logic req_op;
    logic lc_full;
    logic fc_full;
    logic i_lt_fc;
    logic i1_lt_fc;
    logic k_gt_i;
    logic j_lt_lc;
    logic j1_lt_lc;
    logic fit;
    logic gt;
    logic lhit;
    logic lzero;
    logic beyond;
    logic prev_hit;
    logic next_hit;
  } ffpa_sts_t;

endpackage

// ===== hdl/ffpa_ctrl.sv =====
// Sequencer of the first-fit pool allocator: steps scans, shifts and merges.
module ffpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  ffpa_pkg::ffpa_sts_t sts_i,
  output ffpa_pkg::ffpa_cmd_t cmd_o
);
  import ffpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_A_CHK, S_A_RD, S_A_CMP, S_A_SPLIT, S_A_LIVE,
    S_RM_RD, S_RM_WR, S_F_LRD, S_F_LCMP, S_F_FRD, S_F_FCMP,
    S_F_DEC, S_INS_RD, S_INS_WR, S_L_RM, S_L_WR
  } state_e;

  state_e state_q, state_d;
  ffpa_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.req_load = 1'b1;
          cmd.i_op     = IX_CLR;
          cmd.j_op     = IX_CLR;
          state_d      = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts_i.req_op == OP_FREE) begin
          state_d = S_F_LRD;
        end else if (sts_i.lc_full) begin
          cmd.done   = 1'b1;
          cmd.status = ST_FULL;
          state_d    = S_IDLE;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        if (!sts_i.i_lt_fc) begin
          cmd.done   = 1'b1;
          cmd.status = ST_NOFIT;
          state_d    = S_IDLE;
        end else begin
          cmd.f_rd_en  = 1'b1;
          cmd.f_rd_sel = FR_I;
          state_d      = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (sts_i.fit) begin
          cmd.grant_save = 1'b1;
          state_d        = sts_i.gt ? S_A_SPLIT : S_RM_RD;
        end else begin
          cmd.i_op = IX_INC;
          state_d  = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        cmd.f_we     = 1'b1;
        cmd.f_wa_sel = FW_I;
        cmd.f_wd_sel = WD_SPLIT;
        state_d      = S_A_LIVE;
      end
      S_A_LIVE: begin
        cmd.l_we     = 1'b1;
        cmd.l_wa_sel = LW_LC;
        cmd.l_wd_sel = LD_NEW;
        cmd.lc_op    = CNT_INC;
        cmd.done     = 1'b1;
        cmd.status   = ST_OK;
        state_d      = S_IDLE;
      end
      // close the gap at free entry i by shifting the tail down
      S_RM_RD: begin
        if (sts_i.i1_lt_fc) begin
          cmd.f_rd_en  = 1'b1;
          cmd.f_rd_sel = FR_I1;
          state_d      = S_RM_WR;
        end else begin
          cmd.fc_op = CNT_DEC;
          state_d   = (sts_i.req_op == OP_FREE) ? S_L_RM : S_A_LIVE;
        end
      end
      S_RM_WR: begin
        cmd.f_we     = 1'b1;
        cmd.f_wa_sel = FW_I;
        cmd.f_wd_sel = WD_COPY;
        cmd.i_op     = IX_INC;
        state_d      = S_RM_RD;
      end
      S_F_LRD: begin
        if (!sts_i.j_lt_lc) begin
          cmd.done   = 1'b1;
          cmd.status = ST_UNKNOWN;
          state_d    = S_IDLE;
        end else begin
          cmd.l_rd_en  = 1'b1;
          cmd.l_rd_sel = LR_J;
          state_d      = S_F_LCMP;
        end
      end
      S_F_LCMP: begin
        if (sts_i.lhit) begin
          cmd.len_save = 1'b1;
          state_d      = sts_i.lzero ? S_L_RM : S_F_FRD;
        end else begin
          cmd.j_op = IX_INC;
          state_d  = S_F_LRD;
        end
      end
      S_F_FRD: begin
        if (!sts_i.i_lt_fc) begin
          state_d = S_F_DEC;
        end else begin
          cmd.f_rd_en  = 1'b1;
          cmd.f_rd_sel = FR_I;
          state_d      = S_F_FCMP;
        end
      end
      S_F_FCMP: begin
        if (sts_i.beyond) begin
          state_d = S_F_DEC;
        end else begin
          cmd.prev_save = 1'b1;
          cmd.i_op      = IX_INC;
          state_d       = S_F_FRD;
        end
      end
      S_F_DEC: begin
        if (sts_i.prev_hit && sts_i.next_hit) begin
          cmd.f_we     = 1'b1;
          cmd.f_wa_sel = FW_IM1;
          cmd.f_wd_sel = WD_BOTH;
          state_d      = S_RM_RD;
        end else if (sts_i.prev_hit) begin
          cmd.f_we     = 1'b1;
          cmd.f_wa_sel = FW_IM1;
          cmd.f_wd_sel = WD_PREV;
          state_d      = S_L_RM;
        end else if (sts_i.next_hit) begin
          cmd.f_we     = 1'b1;
          cmd.f_wa_sel = FW_I;
          cmd.f_wd_sel = WD_NEXT;
          state_d      = S_L_RM;
        end else if (sts_i.fc_full) begin
          cmd.done   = 1'b1;
          cmd.status = ST_FULL;
          state_d    = S_IDLE;
        end else begin
          cmd.k_load = 1'b1;
          state_d    = S_INS_RD;
        end
      end
      // open a slot at free entry i by shifting the tail up
      S_INS_RD: begin
        if (sts_i.k_gt_i) begin
          cmd.f_rd_en  = 1'b1;
          cmd.f_rd_sel = FR_KM1;
          state_d      = S_INS_WR;
        end else begin
          cmd.f_we     = 1'b1;
          cmd.f_wa_sel = FW_I;
          cmd.f_wd_sel = WD_NEW;
          cmd.fc_op    = CNT_INC;
          state_d      = S_L_RM;
        end
      end
      S_INS_WR: begin
        cmd.f_we     = 1'b1;
        cmd.f_wa_sel = FW_K;
        cmd.f_wd_sel = WD_COPY;
        cmd.k_dec    = 1'b1;
        state_d      = S_INS_RD;
      end
      S_L_RM: begin
        if (sts_i.j1_lt_lc) begin
          cmd.l_rd_en  = 1'b1;
          cmd.l_rd_sel = LR_J1;
          state_d      = S_L_WR;
        end else begin
          cmd.lc_op  = CNT_DEC;
          cmd.done   = 1'b1;
          cmd.status = ST_OK;
          state_d    = S_IDLE;
        end
      end
      S_L_WR: begin
        cmd.l_we     = 1'b1;
        cmd.l_wa_sel = LW_J;
        cmd.l_wd_sel = LD_COPY;
        cmd.j_op     = IX_INC;
        state_d      = S_L_RM;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hdl/ffpa_dp.sv =====
// Datapath of the first-fit pool allocator: tables, counters, compares, result.
module ffpa_dp #(
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned LIVE_ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffpa_pkg::LenW-1:0]  cfg_wdata_i,
  input  ffpa_pkg::ffpa_req_t        req_i,
  input  ffpa_pkg::ffpa_cmd_t        cmd_i,
  output ffpa_pkg::ffpa_sts_t        sts_o,
  output logic                       done_o,
  output ffpa_pkg::ffpa_rsp_t        rsp_o
);
  import ffpa_pkg::*;

  localparam int unsigned FIW = $clog2(FREE_ENTRIES);
  localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned LIW = $clog2(LIVE_ENTRIES);
  localparam int unsigned LCW = $clog2(LIVE_ENTRIES + 1);

  ffpa_ext_t f_mem [FREE_ENTRIES];
  ffpa_ext_t l_mem [LIVE_ENTRIES];

  logic [LenW-1:0] pool_q;
  logic            fresh_q, fresh_rd_q;
  logic [FCW-1:0]  fc_q, i_q, k_q;
  logic [LCW-1:0]  lc_q, j_q;
  ffpa_req_t       req_q;
  ffpa_ext_t       f_mem_q, l_rd_q, prev_q, f_rd;
  logic [LenW-1:0] len_q;
  logic [AddrW-1:0] grant_q;
  logic            done_q;
  ffpa_rsp_t       rsp_q;

  logic [FCW-1:0]  f_ra, f_wa;
  logic [LCW-1:0]  l_ra, l_wa;
  ffpa_ext_t       f_wd, l_wd;
  logic [LenW-1:0] cfg_pool;

  assign f_rd = fresh_rd_q ? ffpa_ext_t'{start: '0, len: pool_q} : f_mem_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_pool = LenW'(1);
    end else if (cfg_wdata_i > PoolMax) begin
      cfg_pool = PoolMax;
    end else begin
      cfg_pool = cfg_wdata_i;
    end
  end

  always_comb begin
    case (cmd_i.f_rd_sel)
      FR_I1:   f_ra = i_q + FCW'(1);
      FR_KM1:  f_ra = k_q - FCW'(1);
      default: f_ra = i_q;
    endcase
    case (cmd_i.f_wa_sel)
      FW_IM1:  f_wa = i_q - FCW'(1);
      FW_K:    f_wa = k_q;
      default: f_wa = i_q;
    endcase
    case (cmd_i.f_wd_sel)
      WD_SPLIT: f_wd = '{start: f_rd.start + req_q.size[AddrW-1:0],
                         len: f_rd.len - req_q.size};
      WD_COPY:  f_wd = f_rd;
      WD_BOTH:  f_wd = '{start: prev_q.start, len: prev_q.len + len_q + f_rd.len};
      WD_PREV:  f_wd = '{start: prev_q.start, len: prev_q.len + len_q};
      WD_NEXT:  f_wd = '{start: req_q.address, len: f_rd.len + len_q};
      default:  f_wd = '{start: req_q.address, len: len_q};
    endcase
    l_ra = (cmd_i.l_rd_sel == LR_J1) ? j_q + LCW'(1) : j_q;
    l_wa = (cmd_i.l_wa_sel == LW_J) ? j_q : lc_q;
    l_wd = (cmd_i.l_wd_sel == LD_COPY) ? l_rd_q :
           ffpa_ext_t'{start: grant_q, len: req_q.size};
  end

  // tables: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.f_we) begin
      f_mem[f_wa[FIW-1:0]] <= f_wd;
    end
    if (cmd_i.f_rd_en) begin
      f_mem_q <= f_mem[f_ra[FIW-1:0]];
    end
    if (cmd_i.l_we) begin
      l_mem[l_wa[LIW-1:0]] <= l_wd;
    end
    if (cmd_i.l_rd_en) begin
      l_rd_q <= l_mem[l_ra[LIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= req_i;
    end
    if (cmd_i.prev_save) begin
      prev_q <= f_rd;
    end
    if (cmd_i.len_save) begin
      len_q <= l_rd_q.len;
    end
    if (cmd_i.grant_save) begin
      grant_q <= f_rd.start;
    end
    if (cmd_i.k_load) begin
      k_q <= fc_q;
    end else if (cmd_i.k_dec) begin
      k_q <= k_q - FCW'(1);
    end
    case (cmd_i.i_op)
      IX_CLR:  i_q <= '0;
      IX_INC:  i_q <= i_q + FCW'(1);
      default: i_q <= i_q;
    endcase
    case (cmd_i.j_op)
      IX_CLR:  j_q <= '0;
      IX_INC:  j_q <= j_q + LCW'(1);
      default: j_q <= j_q;
    endcase
    if (cmd_i.done) begin
      rsp_q.status         <= cmd_i.status;
      rsp_q.result_address <= (cmd_i.status == ST_OK && req_q.op == OP_ALLOC) ?
                              grant_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q     <= PoolMax;
      fresh_q    <= 1'b1;
      fresh_rd_q <= 1'b0;
      fc_q       <= FCW'(1);
      lc_q       <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.done;
      if (cmd_i.f_rd_en) begin
        fresh_rd_q <= fresh_q && (f_ra == '0);
      end
      if (cfg_we_i) begin
        pool_q  <= cfg_pool;
        fresh_q <= 1'b1;
        fc_q    <= FCW'(1);
        lc_q    <= '0;
      end else begin
        if (cmd_i.f_we && f_wa == '0) begin
          fresh_q <= 1'b0;
        end
        case (cmd_i.fc_op)
          CNT_INC: fc_q <= fc_q + FCW'(1);
          CNT_DEC: fc_q <= fc_q - FCW'(1);
          default: fc_q <= fc_q;
        endcase
        case (cmd_i.lc_op)
          CNT_INC: lc_q <= lc_q + LCW'(1);
          CNT_DEC: lc_q <= lc_q - LCW'(1);
          default: lc_q <= lc_q;
        endcase
      end
    end
  end

  always_comb begin
    sts_o.req_op   = req_q.op;
    sts_o.lc_full  = (lc_q >= LCW'(LIVE_ENTRIES));
    sts_o.fc_full  = (fc_q >= FCW'(FREE_ENTRIES));
    sts_o.i_lt_fc  = (i_q < fc_q);
    sts_o.i1_lt_fc = (({1'b0, i_q} + (FCW+1)'(1)) < {1'b0, fc_q});
    sts_o.k_gt_i   = (k_q > i_q);
    sts_o.j_lt_lc  = (j_q < lc_q);
    sts_o.j1_lt_lc = (({1'b0, j_q} + (LCW+1)'(1)) < {1'b0, lc_q});
    sts_o.fit      = (f_rd.len >= req_q.size);
    sts_o.gt       = (f_rd.len > req_q.size);
    sts_o.lhit     = (l_rd_q.start == req_q.address);
    sts_o.lzero    = (l_rd_q.len == '0);
    sts_o.beyond   = (f_rd.start > req_q.address);
    sts_o.prev_hit = (i_q != '0) &&
                     ((LenW'(prev_q.start) + prev_q.len) == LenW'(req_q.address));
    sts_o.next_hit = (i_q < fc_q) &&
                     ((LenW'(req_q.address) + len_q) == LenW'(f_rd.start));
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FCW'(FREE_ENTRIES)) else $error("free count beyond table");
  a_lc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q <= LCW'(LIVE_ENTRIES)) else $error("live count beyond table");
  a_fwr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.f_we |-> f_wa < FCW'(FREE_ENTRIES)) else $error("free write out of range");
`endif

endmodule

// ===== hdl/first_fit_pool_allocator.sv =====
// Top level of the first-fit pool allocator: sequencer plus datapath.
//
// Usage: drive req_i (op, size, address) and raise start_i while busy_o is
// low; the item is taken at that edge. One result per item appears on rsp_o
// with done_o high for exactly one cycle; the receiver cannot hold it off.
// An allocate returns the offset of the lowest free extent that fits, or
// no-fit / table-full status. A free looks up the allocation, returns it to
// the address-sorted free table and merges it with touching neighbors.
//
// Stepping: each table entry visited passes through the single registered read
// port of the free or live table. A scan and the shift that follows it
// together cover one table once. The longest item is a free that scans both
// tables and opens a new free slot.
// done_o rises in the first cycle that busy_o is low again, so the next
// item may be started in the same cycle that a result is shown.
//
// Reset: the pool is 65536 bytes in one free extent, no allocations. A
// pool_size write (cfg_we_i, only while idle) restarts the pool the same way, at the written size clamped to 1..65536.
module first_fit_pool_allocator #(
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned LIVE_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ffpa_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  ffpa_pkg::ffpa_req_t       req_i,
  output logic                      done_o,
  output ffpa_pkg::ffpa_rsp_t       rsp_o
);
  import ffpa_pkg::*;

  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  // sequencer: owns the state, issues at most one table step per cycle
  ffpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath: tables, counters, compares and the result register
  ffpa_dp #(
    .FREE_ENTRIES(FREE_ENTRIES),
    .LIVE_ENTRIES(LIVE_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("item taken but not busy");
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.result_address == '0)
    else $error("address on failed item");
`endif

endmodule
